### design/box_downsample_rgb_macros.svh
// Assertion macros used by the box downsampler checker.
`ifndef BOX_DOWNSAMPLE_RGB_MACROS_SVH
`define BOX_DOWNSAMPLE_RGB_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define BDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i that also holds through reset.
`define BDR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/bdr_pkg.sv
// Package with sizes, register indexes and types of the box downsampler.
package bdr_pkg;

  localparam int MaxOutWidth  = 1024;
  localparam int MaxSourceDim = 4096;
  localparam int MaxSamples   = 4;

  localparam int AddrW    = $clog2(MaxOutWidth);
  localparam int PosW     = $clog2(MaxSourceDim);
  localparam int DimW     = PosW + 1;
  localparam int ExtW     = DimW + 1;
  localparam int SampW    = 4;
  localparam int SEffW    = 3;
  localparam int SubW     = 2;
  localparam int ChanW    = 8;
  localparam int SumW     = 12;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 13;

  // Register indexes of the configuration port
  localparam logic [CfgAddrW-1:0] RegSamples      = 2'd0;
  localparam logic [CfgAddrW-1:0] RegSourceWidth  = 2'd1;
  localparam logic [CfgAddrW-1:0] RegSourceHeight = 2'd2;

  // Reciprocal of nine in Q15, rounded down
  localparam int Recip9     = 3640;
  localparam int Recip9Frac = 15;

  typedef struct packed {
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] r;
  } pix_t;

  typedef struct packed {
    logic [SumW-1:0] b;
    logic [SumW-1:0] g;
    logic [SumW-1:0] r;
  } rgb_sum_t;

  typedef struct packed {
    logic             in_range;
    logic             first_col;
    logic             last_col;
    logic             first_row;
    logic             last_row;
    logic             row_end;
    logic             frame_end;
    logic [AddrW-1:0] addr;
  } pix_ctl_t;

endpackage

### design/box_downsample_rgb.sv
// Box-filter downsampler for an RGB pixel stream, top level.
//
//  channel   direction  payload                               handshake
//  s_axis    in         tdata: red, green, blue, alpha        tvalid/tready
//  m_axis    out        tdata: red, green, blue; tuser: row   tvalid/tready
//                       end; tlast: frame end
//  cfg       in         index cfg_addr_i, value cfg_wdata_i   cfg_we_i
//
// One source pixel is taken per cycle. The line memory has one read and one
// write port: a pixel reads its column entry at acceptance and the entry is
// written back one stage later. The sum of a finished block passes from the
// accumulate stage to the divide stage and the output register. Reset and
// any configuration write restart the frame; the line memory keeps its
// content. A stalled output holds the pipeline and the input side.
module box_downsample_rgb import bdr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // red, green, blue, alpha
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // red, green, blue
  output logic                m_axis_tuser,   // row_end
  output logic                m_axis_tlast,   // frame_end
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [SampW-1:0] samples_q;
  logic [DimW-1:0]  width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= SampW'(1);
      width_q   <= DimW'(1024);
      height_q  <= DimW'(1024);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegSamples:      samples_q <= cfg_wdata_i[SampW-1:0];
        RegSourceWidth:  width_q   <= cfg_wdata_i[DimW-1:0];
        RegSourceHeight: height_q  <= cfg_wdata_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the settings to their working ranges
  logic [SEffW-1:0] s_eff;
  logic [DimW-1:0]  w_eff, h_eff;

  always_comb begin
    if (samples_q == '0)                     s_eff = SEffW'(1);
    else if (samples_q > SampW'(MaxSamples)) s_eff = SEffW'(MaxSamples);
    else                                     s_eff = samples_q[SEffW-1:0];
    if (width_q == '0)                       w_eff = DimW'(1);
    else if (width_q > DimW'(MaxSourceDim))  w_eff = DimW'(MaxSourceDim);
    else                                     w_eff = width_q;
    if (height_q == '0)                      h_eff = DimW'(1);
    else if (height_q > DimW'(MaxSourceDim)) h_eff = DimW'(MaxSourceDim);
    else                                     h_eff = height_q;
  end

  // Position counters: source x/y, block origin, output column/row, sub-step
  logic [PosW-1:0] x_q, x_d, y_q, y_d;
  logic [PosW-1:0] xs_q, xs_d, ys_q, ys_d;
  logic [PosW-1:0] cc_q, cc_d, rc_q, rc_d;
  logic [SubW-1:0] sc_q, sc_d, sr_q, sr_d;

  logic [ExtW-1:0] bx_end, by_end, nbx_end, nby_end;
  logic            cap_ok, in_x, in_y, last_bx, last_by;
  logic            x_wrap, y_wrap;
  logic            sc_wrap, sr_wrap;
  pix_ctl_t        ctl_in;
  logic            s_acc;

  always_comb begin
    bx_end  = ExtW'(xs_q) + ExtW'(s_eff);
    by_end  = ExtW'(ys_q) + ExtW'(s_eff);
    nbx_end = bx_end + ExtW'(s_eff);
    nby_end = by_end + ExtW'(s_eff);
    cap_ok  = ExtW'(cc_q) < ExtW'(MaxOutWidth);
    in_x    = bx_end <= ExtW'(w_eff);
    in_y    = by_end <= ExtW'(h_eff);
    last_bx = (nbx_end > ExtW'(w_eff)) || (ExtW'(cc_q) == ExtW'(MaxOutWidth - 1));
    last_by = nby_end > ExtW'(h_eff);
    x_wrap  = (DimW'(x_q) + DimW'(1)) >= w_eff;
    y_wrap  = (DimW'(y_q) + DimW'(1)) >= h_eff;
    sc_wrap = (SEffW'(sc_q) + SEffW'(1)) >= s_eff;
    sr_wrap = (SEffW'(sr_q) + SEffW'(1)) >= s_eff;

    ctl_in.in_range  = cap_ok && in_x && in_y;
    ctl_in.first_col = sc_q == '0;
    ctl_in.last_col  = (SEffW'(sc_q) + SEffW'(1)) == s_eff;
    ctl_in.first_row = sr_q == '0;
    ctl_in.last_row  = (SEffW'(sr_q) + SEffW'(1)) == s_eff;
    ctl_in.row_end   = last_bx;
    ctl_in.frame_end = last_bx && last_by;
    ctl_in.addr      = cc_q[AddrW-1:0];
  end

  // Advance the raster position by one pixel
  always_comb begin
    x_d = x_q; y_d = y_q; xs_d = xs_q; ys_d = ys_q;
    cc_d = cc_q; rc_d = rc_q; sc_d = sc_q; sr_d = sr_q;
    if (x_wrap) begin
      x_d = '0; xs_d = '0; cc_d = '0; sc_d = '0;
      if (y_wrap) begin
        y_d = '0; ys_d = '0; rc_d = '0; sr_d = '0;
      end else begin
        y_d = y_q + PosW'(1);
        if (sr_wrap) begin
          sr_d = '0;
          rc_d = rc_q + PosW'(1);
          ys_d = ys_q + PosW'(s_eff);
        end else begin
          sr_d = sr_q + SubW'(1);
        end
      end
    end else begin
      x_d = x_q + PosW'(1);
      if (sc_wrap) begin
        sc_d = '0;
        cc_d = cc_q + PosW'(1);
        xs_d = xs_q + PosW'(s_eff);
      end else begin
        sc_d = sc_q + SubW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; y_q <= '0; xs_q <= '0; ys_q <= '0;
      cc_q <= '0; rc_q <= '0; sc_q <= '0; sr_q <= '0;
    end else if (cfg_we_i) begin
      x_q <= '0; y_q <= '0; xs_q <= '0; ys_q <= '0;
      cc_q <= '0; rc_q <= '0; sc_q <= '0; sr_q <= '0;
    end else if (s_acc) begin
      x_q <= x_d; y_q <= y_d; xs_q <= xs_d; ys_q <= ys_d;
      cc_q <= cc_d; rc_q <= rc_d; sc_q <= sc_d; sr_q <= sr_d;
    end
  end

  // Pipeline handshake: output register, divide stage, accumulate stage
  logic     p1_valid_q, p2_valid_q, out_valid_q;
  pix_ctl_t p1_ctl_q;
  pix_t     p1_pix_q;
  logic     p1_emit, p1_go, p2_free, out_free;

  assign p1_emit       = p1_ctl_q.in_range && p1_ctl_q.last_col && p1_ctl_q.last_row;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign p2_free       = !p2_valid_q || out_free;
  assign p1_go         = p1_valid_q && (!p1_emit || p2_free);
  assign s_axis_tready = !p1_valid_q || p1_go;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Line memory of sub-row partial sums, one entry per output column.
  // A column entry is written on the last pixel of its block in one sub-row
  // and next read at least a whole source row later, so reads and writes of
  // the same entry never meet.
  rgb_sum_t line_mem [MaxOutWidth];
  rgb_sum_t rd_q;
  rgb_sum_t acc, tot;
  logic     mem_re, mem_we;

  assign mem_re = s_acc && ctl_in.in_range && ctl_in.last_col && !ctl_in.first_row;
  assign mem_we = p1_go && p1_ctl_q.in_range && p1_ctl_q.last_col && !p1_ctl_q.last_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[p1_ctl_q.addr] <= tot;
    end
    if (mem_re) begin
      rd_q <= line_mem[ctl_in.addr];
    end
  end

  // Capture the accepted pixel and its position flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      p1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_ctl_q   <= ctl_in;
      p1_pix_q.r <= s_axis_tdata[7:0];
      p1_pix_q.g <= s_axis_tdata[15:8];
      p1_pix_q.b <= s_axis_tdata[23:16];
    end
  end

  // Accumulate across the sub-row, then add the stored sub-rows
  rgb_sum_t bs_q;

  always_comb begin
    acc.r = (p1_ctl_q.first_col ? '0 : bs_q.r) + SumW'(p1_pix_q.r);
    acc.g = (p1_ctl_q.first_col ? '0 : bs_q.g) + SumW'(p1_pix_q.g);
    acc.b = (p1_ctl_q.first_col ? '0 : bs_q.b) + SumW'(p1_pix_q.b);
    tot.r = (p1_ctl_q.first_row ? '0 : rd_q.r) + acc.r;
    tot.g = (p1_ctl_q.first_row ? '0 : rd_q.g) + acc.g;
    tot.b = (p1_ctl_q.first_row ? '0 : rd_q.b) + acc.b;
  end

  always_ff @(posedge clk_i) begin
    if (p1_go && p1_ctl_q.in_range) begin
      bs_q <= acc;
    end
  end

  // Hold the finished block sum for the divide stage
  rgb_sum_t p2_tot_q;
  logic     p2_row_end_q, p2_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (p2_free) begin
      p2_valid_q <= p1_go && p1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_free && p1_go && p1_emit) begin
      p2_tot_q       <= tot;
      p2_row_end_q   <= p1_ctl_q.row_end;
      p2_frame_end_q <= p1_ctl_q.frame_end;
    end
  end

  // Floor of sum over samples squared: shifts, or a reciprocal with one fix-up
  function automatic logic [ChanW-1:0] box_avg(logic [SumW-1:0] sum, logic [SEffW-1:0] s);
    logic [2*SumW-1:0]          prod;
    logic [SumW-Recip9Frac+SumW-1:0] q;
    logic [SumW:0]              rem;
    logic [ChanW-1:0]           res;
    prod = sum * SumW'(Recip9);
    q    = prod[2*SumW-1:Recip9Frac];
    rem  = (SumW+1)'(sum) - (SumW+1)'({q, 3'b000} + (SumW+1)'(q));
    case (s)
      3'd1:    res = sum[ChanW-1:0];
      3'd2:    res = sum[ChanW+1:2];
      3'd3:    res = (rem >= (SumW+1)'(9)) ? ChanW'(q + 1'b1) : ChanW'(q);
      3'd4:    res = sum[ChanW+3:4];
      default: res = sum[ChanW-1:0];
    endcase
    return res;
  endfunction

  // Output register
  pix_t out_pix_q;
  logic out_row_end_q, out_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && p2_valid_q) begin
      out_pix_q.r     <= box_avg(p2_tot_q.r, s_eff);
      out_pix_q.g     <= box_avg(p2_tot_q.g, s_eff);
      out_pix_q.b     <= box_avg(p2_tot_q.b, s_eff);
      out_row_end_q   <= p2_row_end_q;
      out_frame_end_q <= p2_frame_end_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_row_end_q;
  assign m_axis_tlast  = out_frame_end_q;

endmodule

### design/bdr_checker.sv
// Port-level checker for the box downsampler and its bind.
`include "box_downsample_rgb_macros.svh"

module bdr_checker import bdr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [31:0]         s_axis_tdata,   // red, green, blue, alpha
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [23:0]         m_axis_tdata,   // red, green, blue
  input logic                m_axis_tuser,   // row_end
  input logic                m_axis_tlast,   // frame_end
  input logic                cfg_we_i,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [CfgDataW-1:0] cfg_wdata_i
);

  // The last pixel of a frame always closes an output row
  `BDR_ASSERT(a_frame_ends_row, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser, "frame end without row end")

  // Nothing comes out right after reset: results need a filled pipeline
  `BDR_ASSERT_RST(a_quiet_after_rst, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

  // A stalled transaction keeps its payload
  `BDR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")

endmodule

bind box_downsample_rgb bdr_checker u_bdr_checker (.*);

### tb/sv/tb_box_downsample_rgb.sv
// Self-checking testbench for the box_downsample_rgb RGB box-filter downsampler.
`timescale 1ns / 100ps

module tb_box_downsample_rgb;
  import bdr_pkg::*;

  // Index past the register list: changes nothing, restarts the frame
  localparam logic [CfgAddrW-1:0] RegUnused = 2'd3;

  localparam int SettleCycles = 8;
  localparam int DrainCycles  = 20;
  localparam int RandomPixels = 540;
  localparam int DirRows      = 34;

  typedef struct packed {
    logic             frame_end;
    logic             row_end;
    logic [ChanW-1:0] b;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] r;
  } out_beat_t;

  typedef enum logic {RowPix, RowCfg} row_kind_e;
  typedef enum logic [1:0] {ChkPredict, ChkNone, ChkBeat} check_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgAddrW-1:0]   addr;
    logic [CfgDataW-1:0]   value;
    logic [31:0]           data;
    check_e                chk;
    out_beat_t             want;
  } dir_row_t;

  localparam out_beat_t NoBeat = '0;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;   // red, green, blue, alpha
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;          // red, green, blue
  logic                m_axis_tuser;          // row_end
  logic                m_axis_tlast;          // frame_end
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;

  // Predictor state: register copies, line memory and frame position
  logic [SampW-1:0]    cfg_samples = SampW'(1);
  logic [CfgDataW-1:0] cfg_width   = CfgDataW'(1024);
  logic [CfgDataW-1:0] cfg_height  = CfgDataW'(1024);
  rgb_sum_t            line_sum [MaxOutWidth];
  rgb_sum_t            run_sum;
  int                  out_col, out_row, sub_col, sub_row;

  out_beat_t averages_q [$];
  int        mismatch_n;
  int        pixel_n;

  // Receiver idling state
  bit        rx_calm;
  int        calm_left;
  int        stall_left;

  // Directed stimulus; typed results where they follow at a glance
  dir_row_t dir_tbl [DirRows] = '{
    // reset setting: samples 1, every pixel passes straight through
    '{RowPix, RegSamples, 13'd0, 32'h0000_0000, ChkBeat, '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00}},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkBeat, '{1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF}},
    '{RowPix, RegSamples, 13'd0, 32'h0012_3456, ChkBeat, '{1'b0, 1'b0, 8'h12, 8'h34, 8'h56}},
    '{RowPix, RegSamples, 13'd0, 32'hA500_0000, ChkBeat, '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00}},
    // zero dimensions act as one: a single-pixel frame
    '{RowCfg, RegSourceWidth,  13'd0, 32'h0, ChkNone, NoBeat},
    '{RowCfg, RegSourceHeight, 13'd0, 32'h0, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h8040_2010, ChkBeat, '{1'b1, 1'b1, 8'h40, 8'h20, 8'h10}},
    // samples of zero acts as one
    '{RowCfg, RegSamples, 13'd0, 32'h0, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h7FFF_FFFF, ChkBeat, '{1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF}},
    // samples of 15 acts as 4: image smaller than one block
    '{RowCfg, RegSamples, 13'd15, 32'h0, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h0000_0000, ChkNone, NoBeat},
    // 2x2 frame, first sub-row then a restart by an unlisted index
    '{RowCfg, RegSamples,      13'd2, 32'h0, ChkNone, NoBeat},
    '{RowCfg, RegSourceWidth,  13'd2, 32'h0, ChkNone, NoBeat},
    '{RowCfg, RegSourceHeight, 13'd2, 32'h0, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowCfg, RegUnused, 13'h1FFF, 32'h0, ChkNone, NoBeat},
    // full block: three white pixels and one black, floor(765 / 4)
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h0000_0000, ChkBeat, '{1'b1, 1'b1, 8'hBF, 8'hBF, 8'hBF}},
    // 3x3 block, divide by nine
    '{RowCfg, RegSamples,      13'd3, 32'h0, ChkNone, NoBeat},
    '{RowCfg, RegSourceWidth,  13'd3, 32'h0, ChkNone, NoBeat},
    '{RowCfg, RegSourceHeight, 13'd3, 32'h0, ChkNone, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h1122_3344, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hFFFF_FFFF, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h0000_0000, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h01FE_01FE, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h8080_8080, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h7F7F_7F7F, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hDEAD_BEEF, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'h0F0F_0F0F, ChkPredict, NoBeat},
    '{RowPix, RegSamples, 13'd0, 32'hF0F0_F0F0, ChkPredict, NoBeat}
  };

  box_downsample_rgb uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Favor full-scale channels now and then to reach the largest sums
  function automatic logic [31:0] pick_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'hFFFF_FFFF;
    if (roll < 15) return 32'h0000_0000;
    return $urandom();
  endfunction

  // Accumulate one source pixel; return 1 with the averaged pixel when a block completes
  function automatic bit average_block(input pix_t px, output out_beat_t res);
    int       s, w, h, ow, oh, x, y;
    rgb_sum_t acc, tot;
    bit       done;
    s = (cfg_samples == 0) ? 1 : ((cfg_samples > MaxSamples) ? MaxSamples : int'(cfg_samples));
    w = (cfg_width == 0) ? 1 : ((cfg_width > MaxSourceDim) ? MaxSourceDim : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : ((cfg_height > MaxSourceDim) ? MaxSourceDim : int'(cfg_height));
    ow = w / s;
    oh = h / s;
    if (ow > MaxOutWidth) ow = MaxOutWidth;
    done = 1'b0;
    res = NoBeat;

    // Add into the block; fold into the line memory at the block's right edge
    if (out_col < ow && out_row < oh) begin
      acc.r = ((sub_col == 0) ? '0 : run_sum.r) + SumW'(px.r);
      acc.g = ((sub_col == 0) ? '0 : run_sum.g) + SumW'(px.g);
      acc.b = ((sub_col == 0) ? '0 : run_sum.b) + SumW'(px.b);
      if (sub_col == s - 1) begin
        tot.r = ((sub_row == 0) ? '0 : line_sum[out_col].r) + acc.r;
        tot.g = ((sub_row == 0) ? '0 : line_sum[out_col].g) + acc.g;
        tot.b = ((sub_row == 0) ? '0 : line_sum[out_col].b) + acc.b;
        if (sub_row == s - 1) begin
          res.r         = ChanW'(tot.r / (s * s));
          res.g         = ChanW'(tot.g / (s * s));
          res.b         = ChanW'(tot.b / (s * s));
          res.row_end   = (out_col == ow - 1);
          res.frame_end = (out_col == ow - 1) && (out_row == oh - 1);
          done = 1'b1;
        end else begin
          line_sum[out_col] = tot;
        end
      end
      run_sum = acc;
    end

    // Advance the raster position, wrapping at row and frame ends
    x = out_col * s + sub_col;
    y = out_row * s + sub_row;
    if (x + 1 >= w) begin
      out_col = 0;
      sub_col = 0;
      if (y + 1 >= h) begin
        out_row = 0;
        sub_row = 0;
      end else begin
        sub_row++;
        if (sub_row >= s) begin
          sub_row = 0;
          out_row++;
        end
      end
    end else begin
      sub_col++;
      if (sub_col >= s) begin
        sub_col = 0;
        out_col++;
      end
    end
    return done;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_n++;
    end
  endfunction

  // Offer one pixel, hold it until accepted, then queue what it yields
  task automatic push_pixel(input logic [31:0] data, input check_e chk, input out_beat_t want);
    out_beat_t avg;
    bit        hit;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    hit = average_block(data[23:0], avg);
    pixel_n++;
    if (chk == ChkBeat) averages_q.push_back(want);
    else if (chk == ChkPredict && hit) averages_q.push_back(avg);
  endtask

  task automatic take_gap(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input int n, input bit calm);
    repeat (n) begin
      push_pixel(pick_pixel(), ChkPredict, NoBeat);
      if (!calm) take_gap(pick_idle());
    end
  endtask

  // Drain the block, then write one register; any write restarts the frame
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] value);
    int settled;
    s_axis_tvalid <= 1'b0;
    while (averages_q.size() != 0) @(posedge clk_i);
    settled = 0;
    while (settled < SettleCycles) begin
      @(posedge clk_i);
      if (m_axis_tready) settled++;
    end
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      RegSamples:      cfg_samples = value[SampW-1:0];
      RegSourceWidth:  cfg_width   = value;
      RegSourceHeight: cfg_height  = value;
      default: ;
    endcase
    run_sum = '0;
    out_col = 0;
    out_row = 0;
    sub_col = 0;
    sub_row = 0;
  endtask

  // Receive side: check each output transaction, idle the ready at random
  always @(posedge clk_i) begin
    out_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tlast, m_axis_tuser, m_axis_tdata[23:16], m_axis_tdata[15:8],
              m_axis_tdata[7:0]};
      if (averages_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual %h", $time, got);
        mismatch_n++;
      end else begin
        want = averages_q.pop_front();
        compare_field("red", want.r, got.r);
        compare_field("green", want.g, got.g);
        compare_field("blue", want.b, got.b);
        compare_field("row_end", 8'(want.row_end), 8'(got.row_end));
        compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
      end
    end
    if (calm_left == 0) begin
      rx_calm   = !rx_calm;
      calm_left = $urandom_range(20, 300);
    end else begin
      calm_left--;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 30) stall_left = pick_idle() + 1;
    end
  end

  // Stimulus: directed table, then random frames
  initial begin
    logic [CfgDataW-1:0] wid, hgt;
    int                  w_eff, h_eff;
    bit                  calm;
    run_sum = '0;
    out_col = 0;
    out_row = 0;
    sub_col = 0;
    sub_row = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == RowCfg) begin
        write_reg(dir_tbl[i].addr, dir_tbl[i].value);
      end else begin
        push_pixel(dir_tbl[i].data, dir_tbl[i].chk, dir_tbl[i].want);
        take_gap(pick_idle());
      end
    end

    // Small random frames, mostly whole, some cut short
    pixel_n = 0;
    while (pixel_n < RandomPixels) begin
      if ($urandom_range(0, 7) == 0) write_reg(RegUnused, 13'($urandom()));
      write_reg(RegSamples, ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 15))
                                                         : 13'($urandom_range(1, 4)));
      wid = 13'($urandom_range(0, 14));
      hgt = 13'($urandom_range(0, 12));
      write_reg(RegSourceWidth, wid);
      write_reg(RegSourceHeight, hgt);
      w_eff = (wid == 0) ? 1 : int'(wid);
      h_eff = (hgt == 0) ? 1 : int'(hgt);
      calm  = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) send_run($urandom_range(1, w_eff * h_eff), calm);
      else send_run(w_eff * h_eff * $urandom_range(1, 2), calm);
    end

    // Wait out the remaining results, then watch for stray ones
    s_axis_tvalid <= 1'b0;
    while (averages_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_n == 0) begin
      $display("** box_downsample_rgb: PASSED **");
    end else begin
      $display("** box_downsample_rgb: FAILED **");
    end
    $finish;
  end

  // About 900 pixels and their register writes at worst stalls, many times over
  initial begin
    #(64'd2_000_000);
    $display("** box_downsample_rgb: FAILED **");
    $finish;
  end

endmodule
